// ----- hdl/k_way_merge_winner_tree_top_assert.svh -----
// ----------------------------------------------------------------------------
// k-way merge winner tree: assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_WINNER_TREE_TOP_ASSERT_SVH
`define K_WAY_MERGE_WINNER_TREE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define KMWT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define KMWT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/kmwt_pkg.sv -----
// ----------------------------------------------------------------------------
// k-way merge winner tree package
// port widths, bit positions and controller state codes
// ----------------------------------------------------------------------------
`default_nettype none

package kmwt_pkg;

    localparam int KEY_W       = 64;
    localparam int RUN_OUT_W   = 4;
    localparam int CFG_W       = 5;
    localparam int MIN_RUNS    = 2;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - RUN_OUT_W;
    localparam int USER_W      = 2;
    localparam int EMIT_BIT    = 0;
    localparam int DONE_BIT    = 1;

    localparam logic [CFG_W-1:0] RUN_COUNT_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLIMB = 3'b010,
        ST_HOLD  = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/kmwt_tree_ram.sv -----
// ----------------------------------------------------------------------------
// tree storage
// single write port, single read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module kmwt_tree_ram #(
    parameter int DEPTH  = 31,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 68
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/k_way_merge_winner_tree_top.sv -----
// ----------------------------------------------------------------------------
// k-way merge winner tree
// tournament tree merging sorted runs of keys, with duplicate flagging
// ----------------------------------------------------------------------------
// Merges up to MAX_RUNS sorted runs. The first run_count items (run_count
// clamped to MIN_RUNS..MAX_RUNS) load the head key of runs 0, 1, ... in order;
// the item that loads the last run yields the first result. Every later item
// refills the run named by the previous result's winner_run (set run_end when
// that run is exhausted). Each item writes its leaf and then climbs the leaf's
// path to the root, one tree level per cycle through a single-read-port tree
// memory; the path has ceil(log2(MAX_RUNS)) levels, or one less for some
// leaves when MAX_RUNS is not a power of two. A result
// waiting in the output register stalls the block only when the next result
// is ready. A done result (all runs exhausted) returns the block to loading,
// as does a write of run_count, which is taken only while the block is idle
// and holds no result. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module k_way_merge_winner_tree_top #(
    parameter int MAX_RUNS = 16,
    parameter int KEY_BITS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input items
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [kmwt_pkg::KEY_W-1:0]         s_tdata,   // key
    input  wire logic [0:0]                         s_tuser,   // run_end
    // result items
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [kmwt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // winner_key, winner_run
    output logic      [kmwt_pkg::USER_W-1:0]        m_tuser,   // emit, done_res
    // run_count register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [kmwt_pkg::CFG_W-1:0]         cfg_data
);

    import kmwt_pkg::*;

    localparam int NODES   = MAX_RUNS - 1;
    localparam int POS     = 2 * MAX_RUNS - 1;
    localparam int POS_W   = $clog2(POS);
    localparam int RUN_W   = $clog2(MAX_RUNS);
    localparam int NODE_IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W   = $clog2(MAX_RUNS + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W   = KEY_BITS + RUN_W;

    function automatic logic [POS_W-1:0] sib_of(input logic [POS_W-1:0] h);
        sib_of = h[0] ? h + POS_W'(1) : h - POS_W'(1);
    endfunction

    // control state
    state_t              state_reg,      state_next;
    logic [CFG_W-1:0]    run_count_reg,  run_count_next;
    logic [CNT_W-1:0]    load_cnt_reg,   load_cnt_next;
    logic [MAX_RUNS-1:0] leaf_live_reg,  leaf_live_next;
    logic [NODES-1:0]    node_live_reg,  node_live_next;
    logic                have_last_reg,  have_last_next;
    logic                cur_live_reg,   cur_live_next;
    logic [POS_W-1:0]    pos_reg,        pos_next;
    logic                want_res_reg,   want_res_next;
    logic                m_tvalid_reg,   m_tvalid_next;

    // payload
    logic [RUN_W-1:0]       cur_run_reg,   cur_run_next;
    logic [KEY_BITS-1:0]    cur_key_reg,   cur_key_next;
    logic [KEY_BITS-1:0]    last_key_reg,  last_key_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic [USER_W-1:0]      out_tuser_reg, out_tuser_next;

    // tree memory ports
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [POS_W-1:0] rd_addr;
    logic [ENT_W-1:0] rd_data;

    logic                s_accept;
    logic                cfg_accept;
    logic                out_free;
    logic [CMP_W-1:0]    n_eff;
    logic                loading;
    logic [CNT_W-1:0]    load_inc;
    logic [RUN_W-1:0]    tgt;
    logic [POS_W-1:0]    leaf_pos;
    logic [KEY_BITS-1:0] key_in;
    logic [POS_W-1:0]    sib_pos;
    logic [RUN_W-1:0]    sib_leaf;
    logic                sib_live;
    logic [RUN_W-1:0]    rd_run;
    logic [KEY_BITS-1:0] rd_key;
    logic                cur_lt;
    logic                take_sib;
    logic                par_live;
    logic [RUN_W-1:0]    par_run;
    logic [KEY_BITS-1:0] par_key;
    logic [POS_W-1:0]    par_pos;
    logic                eq_cur;
    logic                eq_sib;

    logic                rep_en;
    logic                rep_live;
    logic [RUN_W-1:0]    rep_run;
    logic [KEY_BITS-1:0] rep_key;
    logic                rep_eq;
    logic                do_clear;

    kmwt_tree_ram #(
        .DEPTH  (POS),
        .ADDR_W (POS_W),
        .DATA_W (ENT_W)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready  = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

    // run count clamped to the supported range
    always_comb
    begin
        if (run_count_reg < CFG_W'(MIN_RUNS))
        begin
            n_eff = CMP_W'(MIN_RUNS);
        end
        else if (CMP_W'(run_count_reg) > CMP_W'(MAX_RUNS))
        begin
            n_eff = CMP_W'(MAX_RUNS);
        end
        else
        begin
            n_eff = CMP_W'(run_count_reg);
        end
    end

    assign loading  = CMP_W'(load_cnt_reg) < n_eff;
    assign load_inc = load_cnt_reg + CNT_W'(1);
    assign tgt      = loading ? load_cnt_reg[RUN_W-1:0] : cur_run_reg;
    assign leaf_pos = POS_W'(NODES) + POS_W'(tgt);
    assign key_in   = s_tdata[KEY_BITS-1:0];

    // one match of the climb: carried winner against the stored sibling
    assign sib_pos  = sib_of(pos_reg);
    assign sib_leaf = RUN_W'(sib_pos - POS_W'(NODES));
    assign sib_live = (sib_pos < POS_W'(NODES)) ? node_live_reg[sib_pos[NODE_IW-1:0]]
                                                : leaf_live_reg[sib_leaf];
    assign rd_run   = rd_data[ENT_W-1:KEY_BITS];
    assign rd_key   = rd_data[KEY_BITS-1:0];
    // runs below a node are distinct, so ties on key fall to the lower run
    assign cur_lt   = {cur_key_reg, cur_run_reg} < {rd_key, rd_run};
    assign take_sib = !(cur_live_reg && (!sib_live || cur_lt));
    assign par_live = cur_live_reg || sib_live;
    assign par_run  = take_sib ? rd_run : cur_run_reg;
    assign par_key  = take_sib ? rd_key : cur_key_reg;
    assign par_pos  = POS_W'((pos_reg - POS_W'(1)) >> 1);

    // dedup compares run beside the match and are selected afterwards
    assign eq_cur = (last_key_reg == cur_key_reg);
    assign eq_sib = (last_key_reg == rd_key);

    always_comb
    begin
        state_next     = state_reg;
        run_count_next = run_count_reg;
        load_cnt_next  = load_cnt_reg;
        leaf_live_next = leaf_live_reg;
        node_live_next = node_live_reg;
        have_last_next = have_last_reg;
        cur_live_next  = cur_live_reg;
        pos_next       = pos_reg;
        want_res_next  = want_res_reg;
        cur_run_next   = cur_run_reg;
        cur_key_next   = cur_key_reg;
        last_key_next  = last_key_reg;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        wr_en    = 1'b0;
        wr_addr  = leaf_pos;
        wr_data  = {tgt, key_in};
        rd_addr  = sib_of(leaf_pos);
        rep_en   = 1'b0;
        rep_live = cur_live_reg;
        rep_run  = cur_run_reg;
        rep_key  = cur_key_reg;
        rep_eq   = eq_cur;
        do_clear = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    run_count_next = cfg_data;
                    do_clear       = 1'b1;
                end
                else if (s_accept)
                begin
                    want_res_next = 1'b1;
                    if (loading)
                    begin
                        load_cnt_next = load_inc;
                        want_res_next = (CMP_W'(load_inc) == n_eff);
                    end
                    if (!loading && !cur_live_reg)
                    begin
                        // nothing live at the root: report done straight away
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        wr_en               = 1'b1;
                        leaf_live_next[tgt] = !s_tuser[0];
                        cur_live_next       = !s_tuser[0];
                        cur_run_next        = tgt;
                        cur_key_next        = key_in;
                        pos_next            = leaf_pos;
                        state_next          = ST_CLIMB;
                    end
                end
            end

            ST_CLIMB:
            begin
                wr_en   = 1'b1;
                wr_addr = par_pos;
                wr_data = {par_run, par_key};
                rd_addr = sib_of(par_pos);
                node_live_next[par_pos[NODE_IW-1:0]] = par_live;
                cur_live_next = par_live;
                cur_run_next  = par_run;
                cur_key_next  = par_key;
                pos_next      = par_pos;
                if (par_pos == '0)
                begin
                    if (!want_res_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        rep_en     = 1'b1;
                        rep_live   = par_live;
                        rep_run    = par_run;
                        rep_key    = par_key;
                        rep_eq     = take_sib ? eq_sib : eq_cur;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    rep_en     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rep_en)
        begin
            m_tvalid_next = 1'b1;
            if (!rep_live)
            begin
                out_tdata_next           = '0;
                out_tuser_next           = '0;
                out_tuser_next[DONE_BIT] = 1'b1;
                do_clear                 = 1'b1;
            end
            else
            begin
                out_tdata_next = {OUT_PAD_W'(0), RUN_OUT_W'(rep_run), KEY_W'(rep_key)};
                out_tuser_next = '0;
                out_tuser_next[EMIT_BIT] = !(have_last_reg && rep_eq);
                last_key_next  = rep_key;
                have_last_next = 1'b1;
            end
        end

        if (do_clear)
        begin
            leaf_live_next = '0;
            node_live_next = '0;
            have_last_next = 1'b0;
            load_cnt_next  = '0;
            cur_live_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_count_reg <= RUN_COUNT_RST;
            load_cnt_reg  <= '0;
            leaf_live_reg <= '0;
            node_live_reg <= '0;
            have_last_reg <= 1'b0;
            cur_live_reg  <= 1'b0;
            pos_reg       <= '0;
            want_res_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_count_reg <= run_count_next;
            load_cnt_reg  <= load_cnt_next;
            leaf_live_reg <= leaf_live_next;
            node_live_reg <= node_live_next;
            have_last_reg <= have_last_next;
            cur_live_reg  <= cur_live_next;
            pos_reg       <= pos_next;
            want_res_reg  <= want_res_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_run_reg   <= cur_run_next;
        cur_key_reg   <= cur_key_next;
        last_key_reg  <= last_key_next;
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
    end

endmodule

`default_nettype wire

// ----- hdl/kmwt_checker.sv -----
// ----------------------------------------------------------------------------
// k-way merge winner tree port checker
// watches the top level's ports and flags protocol and result slips
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_way_merge_winner_tree_top_assert.svh"

module kmwt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [kmwt_pkg::OUT_TDATA_W-1:0]   m_tdata,   // winner_key, winner_run
    input  wire logic [kmwt_pkg::USER_W-1:0]        m_tuser,   // emit, done_res
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready
);

    import kmwt_pkg::*;

    logic             have_reg,     have_next;
    logic [KEY_W-1:0] prev_key_reg, prev_key_next;
    logic             m_accept;

    assign m_accept = m_tvalid && m_tready;

    // last key handed out since the merge started
    always_comb
    begin
        have_next     = have_reg;
        prev_key_next = prev_key_reg;
        if (cfg_valid && cfg_ready)
        begin
            have_next = 1'b0;
        end
        else if (m_accept)
        begin
            have_next     = !m_tuser[DONE_BIT];
            prev_key_next = m_tdata[KEY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_key_reg <= prev_key_next;
    end

    `KMWT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `KMWT_ASSERT_SAME(a_done_clean, m_tvalid && m_tuser[DONE_BIT], (m_tdata == '0) && !m_tuser[EMIT_BIT], "done result carries a key or emit")
    `KMWT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while an item is in the tree")
    `KMWT_ASSERT_SAME(a_dedup, m_accept && !m_tuser[DONE_BIT], m_tuser[EMIT_BIT] == !(have_reg && (prev_key_reg == m_tdata[KEY_W-1:0])), "emit flag disagrees with previous key")

endmodule

bind k_way_merge_winner_tree_top kmwt_checker u_kmwt_checker (.*);

`default_nettype wire

// ----- dv/tb_k_way_merge_winner_tree_top.sv -----
// ----------------------------------------------------------------------------
// k-way merge winner tree testbench
// feeds sorted and broken runs through the merge tree, follows each winner
// with a refill of its run, and checks every result against a tree model
// kept in step with the accepted items
// ----------------------------------------------------------------------------
module tb_k_way_merge_winner_tree_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmwt_pkg::*;

    localparam int RUNS        = 16;
    localparam int NODES       = RUNS - 1;
    localparam int ITEM_TARGET = 620;
    localparam int SETTLE      = 20;

    class winner_tree_scoreboard;
        typedef struct packed {
            logic [KEY_W-1:0]     key;
            logic [RUN_OUT_W-1:0] run;
            logic                 emit;
            logic                 done;
        } winner_t;

        bit [KEY_W-1:0]     leaf_key [RUNS];
        bit                 leaf_live [RUNS];
        bit [RUN_OUT_W-1:0] node_winner [NODES];
        bit                 node_live [NODES];
        bit [KEY_W-1:0]     last_key;
        bit                 have_last;
        int                 load_count;
        bit [CFG_W-1:0]     run_count;
        bit                 merge_finished;
        int                 errors;
        int                 results_seen;
        winner_t            winner_q [$];

        function new();
            run_count = RUN_COUNT_RST;
            clear_merge();
        endfunction

        function void clear_merge();
            for (int i = 0; i < RUNS; i++)
            begin
                leaf_key[i]  = '0;
                leaf_live[i] = 1'b0;
            end
            for (int i = 0; i < NODES; i++)
            begin
                node_winner[i] = '0;
                node_live[i]   = 1'b0;
            end
            last_key   = '0;
            have_last  = 1'b0;
            load_count = 0;
        endfunction

        function int active_runs();
            if (run_count < MIN_RUNS)
                return MIN_RUNS;
            if (run_count > RUNS)
                return RUNS;
            return run_count;
        endfunction

        // heap position: internal node below NODES, leaf of a run above
        function void child_state(input int c, output bit live,
                                  output bit [RUN_OUT_W-1:0] run);
            if (c < NODES)
            begin
                live = node_live[c];
                run  = node_winner[c];
            end
            else
            begin
                live = leaf_live[c - NODES];
                run  = RUN_OUT_W'(c - NODES);
            end
        endfunction

        function void replay(input int p);
            bit                 la, lb;
            bit [RUN_OUT_W-1:0] ra, rb;
            child_state(2 * p + 1, la, ra);
            child_state(2 * p + 2, lb, rb);
            node_live[p] = la || lb;
            if (!la && !lb)
                node_winner[p] = '0;
            else if (!lb)
                node_winner[p] = ra;
            else if (!la)
                node_winner[p] = rb;
            else if (leaf_key[ra] < leaf_key[rb] ||
                     (leaf_key[ra] == leaf_key[rb] && ra < rb))
                node_winner[p] = ra;
            else
                node_winner[p] = rb;
        endfunction

        function bit [RUN_OUT_W-1:0] refill_run();
            bit                 live;
            bit [RUN_OUT_W-1:0] run;
            child_state(0, live, run);
            return run;
        endfunction

        function void push_winner();
            bit                 live;
            bit [RUN_OUT_W-1:0] run;
            winner_t            w;
            child_state(0, live, run);
            if (!live)
            begin
                w.key  = '0;
                w.run  = '0;
                w.emit = 1'b0;
                w.done = 1'b1;
                clear_merge();
                merge_finished = 1'b1;
            end
            else
            begin
                w.key     = leaf_key[run];
                w.run     = run;
                w.emit    = !(have_last && last_key == leaf_key[run]);
                w.done    = 1'b0;
                last_key  = leaf_key[run];
                have_last = 1'b1;
            end
            winner_q.insert(winner_q.size(), w);
        endfunction

        function void note_item(input bit [KEY_W-1:0] key, input bit run_end);
            bit                 live;
            bit [RUN_OUT_W-1:0] run;
            int                 h;
            merge_finished = 1'b0;
            if (load_count < active_runs())
            begin
                leaf_live[load_count] = !run_end;
                leaf_key[load_count]  = run_end ? '0 : key;
                load_count++;
                if (load_count < active_runs())
                    return;
                for (int p = NODES - 1; p >= 0; p--)
                    replay(p);
                push_winner();
                return;
            end
            child_state(0, live, run);
            if (live)
            begin
                leaf_live[run] = !run_end;
                leaf_key[run]  = run_end ? '0 : key;
                h = NODES + run;
                while (h > 0)
                begin
                    h = (h - 1) / 2;
                    replay(h);
                end
            end
            push_winner();
        endfunction

        function void note_config(input bit [CFG_W-1:0] value);
            run_count = value;
            clear_merge();
            merge_finished = 1'b0;
        endfunction

        function int pending();
            return winner_q.size();
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] tdata,
                                   input logic [USER_W-1:0] tuser);
            winner_t got, want;
            got.key  = tdata[KEY_W-1:0];
            got.run  = tdata[KEY_W +: RUN_OUT_W];
            got.emit = tuser[EMIT_BIT];
            got.done = tuser[DONE_BIT];
            results_seen++;
            if (winner_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: key %h run %0d emit %b done %b",
                         $time, got.key, got.run, got.emit, got.done);
                return;
            end
            want = winner_q.pop_front();
            if (got !== want || tdata[OUT_TDATA_W-1:KEY_W+RUN_OUT_W] !== '0)
            begin
                errors++;
                $display("%0t: winner mismatch: expected key %h run %0d emit %b done %b",
                         $time, want.key, want.run, want.emit, want.done);
                $display("%0t:                  actual   key %h run %0d emit %b done %b pad %h",
                         $time, got.key, got.run, got.emit, got.done,
                         tdata[OUT_TDATA_W-1:KEY_W+RUN_OUT_W]);
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [KEY_W-1:0]       s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [USER_W-1:0]      m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data  = '0;

    winner_tree_scoreboard sb = new();

    bit [KEY_W-1:0] run_keys [RUNS][$];
    int             burst_left;
    int             items_total;
    int             cfg_writes;
    int             merges_done;
    int             rx_cyc;

    k_way_merge_winner_tree_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // key
        .s_tuser   (s_tuser),    // run_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // winner_key, winner_run
        .m_tuser   (m_tuser),    // emit, done_res
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result checking and receiver stall pattern, cycling through four moods
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        rx_cyc++;
        case ((rx_cyc / 256) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_cyc % 7) > 2;
            default: m_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    task automatic send_item(input bit [KEY_W-1:0] key, input bit run_end);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= run_end;
        do @(posedge clk); while (!s_tready);
        sb.note_item(key, run_end);
        items_total++;
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
        end
    endtask

    // only while idle: no result outstanding and the last climb has settled
    task automatic write_run_count(input bit [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.note_config(value);
        cfg_writes++;
    endtask

    // style: 0 wide keys, 1 narrow keys full of duplicates, 2 keys near the top,
    // 3 unsorted wide keys
    function automatic void fill_runs(input int n, input int style);
        int             len;
        bit [KEY_W-1:0] k;
        for (int r = 0; r < RUNS; r++)
            run_keys[r].delete();
        for (int r = 0; r < n; r++)
        begin
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            repeat (len)
            begin
                case (style)
                    1:       k = KEY_W'($urandom_range(0, 7));
                    2:       k = ~KEY_W'($urandom_range(0, 15));
                    default: k = {$urandom, $urandom};
                endcase
                run_keys[r].insert(run_keys[r].size(), k);
            end
            if (style != 3)
                run_keys[r].sort();
        end
    endfunction

    // load every run, then keep refilling whichever run the tree says won
    task automatic run_merge(input bit noisy);
        int             r;
        int             steps;
        bit [KEY_W-1:0] k;
        steps = 0;
        sb.merge_finished = 1'b0;
        while (!sb.merge_finished && steps < 300)
        begin
            r = (sb.load_count < sb.active_runs()) ? sb.load_count : sb.refill_run();
            k = {$urandom, $urandom};
            if (noisy && $urandom_range(0, 4) == 0)
                send_item(k, $urandom_range(0, 2) == 0);
            else if (run_keys[r].size() == 0)
                send_item(k, 1'b1);
            else
                send_item(run_keys[r].pop_front(), 1'b0);
            steps++;
        end
        if (sb.merge_finished)
            merges_done++;
    endtask

    initial
    begin
        int             start_items;
        bit [CFG_W-1:0] v;
        burst_left = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset run count: extreme keys, a tie between two runs, a duplicate,
        // runs already exhausted at load time
        fill_runs(0, 0);
        run_keys[0].insert(run_keys[0].size(), {KEY_W{1'b1}});
        run_keys[5].insert(run_keys[5].size(), KEY_W'(0));
        run_keys[9].insert(run_keys[9].size(), KEY_W'(0));
        run_merge(1'b0);

        // count below the minimum, every run empty: done straight from loading
        write_run_count(5'd0);
        fill_runs(0, 0);
        run_merge(1'b0);

        // count above the maximum, then a write that abandons a half-loaded merge
        write_run_count(5'd31);
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'h7fff_ffff_ffff_ffff, 1'b0);
        write_run_count(5'd1);
        run_keys[0].insert(run_keys[0].size(), 64'd3);
        run_keys[1].insert(run_keys[1].size(), 64'd3);
        run_merge(1'b0);

        start_items = items_total;
        while (items_total - start_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       v = 5'd2;
                1:       v = 5'd16;
                2:       v = CFG_W'($urandom_range(0, 31));
                3:       v = CFG_W'($urandom_range(3, 8));
                4:       v = CFG_W'($urandom_range(17, 31));
                default: v = 5'd16;
            endcase
            write_run_count(v);
            repeat ($urandom_range(1, 3))
            begin
                fill_runs(sb.active_runs(), $urandom_range(0, 3));
                run_merge($urandom_range(0, 3) == 0);
                if (!sb.merge_finished)
                    write_run_count(sb.run_count);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("run covered %0d items, %0d results, %0d run count writes, %0d merges to done",
                 items_total, sb.results_seen, cfg_writes, merges_done);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
